// ===== rtl/core/stlb_pkg.sv =====
// shared types, sizes and codes of the scrolling text line buffer
package stlb_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 128;

	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int LINES_W  = $clog2(MAX_ROWS + 1);
	localparam int COLPOS_W = $clog2(MAX_COLS + 1);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;

	localparam int CHAR_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 8'd1;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CHAR_W-1:0] char_code;
		logic              starts_message;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} stlb_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  data_char;
		logic [ROW_W-1:0]   row_physical;
		logic [COL_W-1:0]   column_used;
		logic               wrote;
		logic               row_valid;
		logic [ROW_W-1:0]   oldest_line;
		logic [LINES_W-1:0] lines_held;
	} stlb_res_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic begin_msg;
		logic end_msg;
		logic col_home;
		logic open_line;
		logic fill;
		logic store;
		logic clear;
		logic read;
		logic finish;
	} stlb_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		action_t action;
		logic    starts;
		logic    ended;
		logic    ch_nul;
		logic    ch_cr;
		logic    ch_lf;
		logic    wrap;
		logic    fill_last;
		logic    res_free;
	} stlb_stat_t;

endpackage

// ===== rtl/core/stlb_item_if.sv =====
// input item channel of the line buffer
interface stlb_item_if import stlb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [CHAR_W-1:0] char_code;
	logic              starts_message;
	logic [ROW_W-1:0]  read_row;
	logic [COL_W-1:0]  read_col;

	modport source (
		output valid, action, char_code, starts_message, read_row, read_col,
		input  ready
	);
	modport sink (
		input  valid, action, char_code, starts_message, read_row, read_col,
		output ready
	);
endinterface

// ===== rtl/core/stlb_result_if.sv =====
// result channel of the line buffer
interface stlb_result_if import stlb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  data_char;
	logic [ROW_W-1:0]   row_physical;
	logic [COL_W-1:0]   column_used;
	logic               wrote;
	logic               row_valid;
	logic [ROW_W-1:0]   oldest_line;
	logic [LINES_W-1:0] lines_held;

	modport source (
		output valid, data_char, row_physical, column_used, wrote, row_valid,
		       oldest_line, lines_held,
		input  ready
	);
	modport sink (
		input  valid, data_char, row_physical, column_used, wrote, row_valid,
		       oldest_line, lines_held,
		output ready
	);
endinterface

// ===== rtl/core/stlb_cfg_if.sv =====
// configuration write channel of the line buffer
interface stlb_cfg_if import stlb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== rtl/core/stlb_ram.sv =====
// generic simple dual-port ram with registered read
module stlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/stlb_ctrl.sv =====
// controller state machine of the line buffer
module stlb_ctrl import stlb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       cfg_valid,
	input  stlb_stat_t stat,
	output logic       item_ready,
	output logic       cfg_ready,
	output stlb_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_BODY,
		S_FILL,
		S_STORE,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RET_BODY,
		RET_STORE,
		RET_DONE
	} ret_t;

	state_t state_q;
	state_t state_d;
	ret_t   ret_q;
	ret_t   ret_d;
	logic   idle_q;
	logic   item_acc;

	// configuration takes precedence over a new item while idle
	assign cfg_ready  = idle_q;
	assign item_ready = idle_q && !cfg_valid;
	assign item_acc   = item_valid && item_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					cmd.latch = 1'b1;
					state_d   = S_START;
				end
			end
			S_START: begin
				unique case (stat.action)
					ACT_WRITE: begin
						if (stat.starts) begin
							cmd.begin_msg = 1'b1;
							cmd.open_line = 1'b1;
							ret_d         = RET_BODY;
							state_d       = S_FILL;
						end else begin
							state_d = S_BODY;
						end
					end
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = S_DONE;
					end
					ACT_READ: begin
						cmd.read = 1'b1;
						state_d  = S_DONE;
					end
					ACT_NONE: begin
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_BODY: begin
				if (stat.ended) begin
					state_d = S_DONE;
				end else if (stat.ch_nul) begin
					cmd.end_msg = 1'b1;
					state_d     = S_DONE;
				end else if (stat.ch_cr) begin
					cmd.col_home = 1'b1;
					state_d      = S_DONE;
				end else if (stat.ch_lf) begin
					cmd.open_line = 1'b1;
					ret_d         = RET_DONE;
					state_d       = S_FILL;
				end else if (stat.wrap) begin
					cmd.open_line = 1'b1;
					ret_d         = RET_STORE;
					state_d       = S_FILL;
				end else begin
					state_d = S_STORE;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					unique case (ret_q)
						RET_BODY:  state_d = S_BODY;
						RET_STORE: state_d = S_STORE;
						RET_DONE:  state_d = S_DONE;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (stat.res_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, return point and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= RET_DONE;
			idle_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			idle_q  <= (state_d == S_IDLE);
		end
	end

endmodule

// ===== rtl/core/stlb_datapath.sv =====
// datapath of the line buffer: ring pointers, line store and result register
module stlb_datapath import stlb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stlb_cmd_t             cmd,
	input  stlb_item_t            item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  res_ready,
	output logic                  res_valid,
	output stlb_res_t             res,
	output stlb_stat_t            stat
);

	stlb_item_t          item_q;
	logic [LINES_W-1:0]  rows_q;
	logic [COLPOS_W-1:0] cols_q;
	logic [ROW_W-1:0]    first_q;
	logic [LINES_W-1:0]  count_q;
	logic [ROW_W-1:0]    cur_q;
	logic [COLPOS_W-1:0] colpos_q;
	logic                ended_q;
	logic [COLPOS_W-1:0] fill_cnt_q;
	logic                wrote_q;
	logic [COL_W-1:0]    store_col_q;
	logic                res_valid_q;
	stlb_res_t           res_q;

	action_t             act;
	logic [LINES_W-1:0]  open_sum;
	logic [ROW_W-1:0]    open_slot;
	logic                ring_full;
	logic [LINES_W-1:0]  first_inc;
	logic [ROW_W-1:0]    first_next;
	logic [LINES_W-1:0]  rd_sum;
	logic [ROW_W-1:0]    rd_phys;
	logic                rd_held;
	logic                rd_in_col;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [CHAR_W-1:0]   ram_wdata;
	logic [CHAR_W-1:0]   ram_rdata;
	logic [LINES_W-1:0]  rows_wr;
	logic [COLPOS_W-1:0] cols_wr;
	stlb_res_t           res_d;

	assign act = action_t'(item_q.action);

	// slot of a newly opened line
	assign ring_full  = !(count_q < rows_q);
	assign open_sum   = LINES_W'(first_q) + count_q;
	assign open_slot  = (open_sum >= rows_q) ? ROW_W'(open_sum - rows_q) : ROW_W'(open_sum);
	assign first_inc  = LINES_W'(first_q) + LINES_W'(1);
	assign first_next = (first_inc == rows_q) ? '0 : ROW_W'(first_inc);

	// visible row to ring slot for reads
	assign rd_held   = LINES_W'(item_q.read_row) < count_q;
	assign rd_in_col = COLPOS_W'(item_q.read_col) < cols_q;
	assign rd_sum    = LINES_W'(first_q) + LINES_W'(item_q.read_row);
	assign rd_phys   = (rd_sum >= rows_q) ? ROW_W'(rd_sum - rows_q) : ROW_W'(rd_sum);

	// clamped configuration values
	always_comb begin
		rows_wr = LINES_W'(cfg_data[LINES_W-1:0]);
		if (rows_wr == '0) begin
			rows_wr = LINES_W'(1);
		end else if (rows_wr > LINES_W'(MAX_ROWS)) begin
			rows_wr = LINES_W'(MAX_ROWS);
		end
		cols_wr = COLPOS_W'(cfg_data);
		if (cols_wr == '0) begin
			cols_wr = COLPOS_W'(1);
		end else if (cols_wr > COLPOS_W'(MAX_COLS)) begin
			cols_wr = COLPOS_W'(MAX_COLS);
		end
	end

	// status to the controller
	always_comb begin
		stat.action    = act;
		stat.starts    = item_q.starts_message;
		stat.ended     = ended_q;
		stat.ch_nul    = (item_q.char_code == CHAR_NUL);
		stat.ch_cr     = (item_q.char_code == CHAR_CR);
		stat.ch_lf     = (item_q.char_code == CHAR_LF);
		stat.wrap      = (colpos_q >= cols_q);
		stat.fill_last = (fill_cnt_q == cols_q - COLPOS_W'(1));
		stat.res_free  = !res_valid_q || res_ready;
	end

	// line store write port: space fill or character store
	always_comb begin
		ram_we    = cmd.fill || cmd.store;
		ram_waddr = {cur_q, colpos_q[COL_W-1:0]};
		ram_wdata = item_q.char_code;
		if (cmd.fill) begin
			ram_waddr = {cur_q, fill_cnt_q[COL_W-1:0]};
			ram_wdata = CHAR_SPACE;
		end
	end

	stlb_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read),
		.raddr ({rd_phys, item_q.read_col}),
		.rdata (ram_rdata)
	);

	// item latch and per-item write record
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.store) begin
			store_col_q <= colpos_q[COL_W-1:0];
		end
	end

	// ring state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= LINES_W'(MAX_ROWS);
			cols_q     <= COLPOS_W'(MAX_COLS);
			first_q    <= '0;
			count_q    <= '0;
			cur_q      <= '0;
			colpos_q   <= '0;
			ended_q    <= 1'b1;
			fill_cnt_q <= '0;
			wrote_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROWS_IN_USE) begin
					rows_q <= rows_wr;
				end
				if (cfg_index == REG_COLS_IN_USE) begin
					cols_q <= cols_wr;
				end
			end
			if (cmd.latch) begin
				wrote_q <= 1'b0;
			end
			if (cmd.begin_msg) begin
				ended_q <= 1'b0;
			end
			if (cmd.end_msg) begin
				ended_q <= 1'b1;
			end
			if (cmd.col_home) begin
				colpos_q <= '0;
			end
			// open a line: fresh slot or reuse of the oldest
			if (cmd.open_line) begin
				if (ring_full) begin
					cur_q   <= first_q;
					first_q <= first_next;
				end else begin
					cur_q   <= open_slot;
					count_q <= count_q + LINES_W'(1);
				end
				colpos_q   <= '0;
				fill_cnt_q <= '0;
			end
			if (cmd.fill) begin
				fill_cnt_q <= fill_cnt_q + COLPOS_W'(1);
			end
			if (cmd.store) begin
				colpos_q <= colpos_q + COLPOS_W'(1);
				wrote_q  <= 1'b1;
			end
			// clear, or a write to the rows or columns register, empties the ring
			if (cmd.clear || (cfg_we && (cfg_index == REG_ROWS_IN_USE ||
					cfg_index == REG_COLS_IN_USE))) begin
				first_q  <= '0;
				count_q  <= '0;
				cur_q    <= '0;
				colpos_q <= '0;
				ended_q  <= 1'b1;
			end
		end
	end

	// result of the finished item
	always_comb begin
		res_d             = '0;
		res_d.oldest_line = first_q;
		res_d.lines_held  = count_q;
		case (act)
			ACT_WRITE: begin
				res_d.data_char    = item_q.char_code;
				res_d.row_physical = cur_q;
				res_d.column_used  = wrote_q ? store_col_q : '0;
				res_d.wrote        = wrote_q;
			end
			ACT_READ: begin
				res_d.column_used  = item_q.read_col;
				res_d.row_valid    = rd_held;
				res_d.row_physical = rd_held ? rd_phys : '0;
				res_d.data_char    = (rd_held && rd_in_col) ? ram_rdata : CHAR_SPACE;
			end
			default: begin
				res_d.data_char = '0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/scrolling_text_line_buffer.sv =====
// top level of the scrolling text line buffer
//
// Character terminal line store: text lines sit in a ring of rows_in_use slots,
// each cols_in_use characters wide, held in a 4096 x 8 line store ram. Each
// transaction on cmd gives one transaction on rsp. One item is worked on at a
// time; the next is taken once the previous result sits in the output register.
// A read, clear or unused action passes the start and done states; an ignored
// or control character (nul, carriage return, message outside) also the body
// state, and a stored character the body and store states. Every line opened
// (message start, newline or wrap at the column limit) adds a space fill of
// cols_in_use columns, one column a cycle through the ram write port. Register
// writes are taken only while idle; each rows or cols write empties the ring.
module scrolling_text_line_buffer import stlb_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	stlb_item_if.sink    cmd,
	stlb_result_if.source rsp,
	stlb_cfg_if.sink     cfg
);

	stlb_cmd_t  ctl_cmd;
	stlb_stat_t dp_stat;
	stlb_item_t item;
	stlb_res_t  res;
	logic       res_valid;
	logic       item_ready;
	logic       cfg_ready;

	// pack the input payload
	assign item.action         = cmd.action;
	assign item.char_code      = cmd.char_code;
	assign item.starts_message = cmd.starts_message;
	assign item.read_row       = cmd.read_row;
	assign item.read_col       = cmd.read_col;
	assign cmd.ready           = item_ready;
	assign cfg.ready           = cfg_ready;

	stlb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cmd.valid),
		.cfg_valid  (cfg.valid),
		.stat       (dp_stat),
		.item_ready (item_ready),
		.cfg_ready  (cfg_ready),
		.cmd        (ctl_cmd)
	);

	stlb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.item      (item),
		.cfg_we    (cfg.valid && cfg_ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_ready (rsp.ready),
		.res_valid (res_valid),
		.res       (res),
		.stat      (dp_stat)
	);

	// unpack the result payload
	assign rsp.valid        = res_valid;
	assign rsp.data_char    = res.data_char;
	assign rsp.row_physical = res.row_physical;
	assign rsp.column_used  = res.column_used;
	assign rsp.wrote        = res.wrote;
	assign rsp.row_valid    = res.row_valid;
	assign rsp.oldest_line  = res.oldest_line;
	assign rsp.lines_held   = res.lines_held;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench of the scrolling text line buffer
`timescale 1ns / 100ps

module testbench;
	import stlb_pkg::*;

	localparam int LIMIT  = 1_500_000;
	localparam int SETTLE = 20;
	localparam int BUDGET = 80;

	// line ring predictor with a queue of the results still owed by the block
	class line_scoreboard;
		bit [CHAR_W-1:0] text [MAX_ROWS*MAX_COLS];
		int unsigned     rows, cols;
		int unsigned     first_line, line_count, current_line, column_pos;
		bit              message_ended;
		stlb_res_t       pending_results [$];
		int              errors, results_seen;

		function new();
			rows = MAX_ROWS;
			cols = MAX_COLS;
			errors = 0;
			results_seen = 0;
			empty_ring();
		endfunction

		function void empty_ring();
			first_line = 0;
			line_count = 0;
			current_line = 0;
			column_pos = 0;
			message_ended = 1'b1;
		endfunction

		// take a fresh slot, or the oldest one once the ring is full, and blank it
		function void open_line();
			int unsigned slot;
			if (line_count < rows) begin
				slot = (first_line + line_count) % rows;
				line_count++;
			end else begin
				slot = first_line;
				first_line = (first_line + 1) % rows;
			end
			for (int j = 0; j < cols; j++)
				text[slot*MAX_COLS + j] = CHAR_SPACE;
			current_line = slot;
			column_pos = 0;
		endfunction

		function int unsigned clamp_reg(int unsigned v, int unsigned hi);
			if (v < 1)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// register write: out of range values are clamped, and the ring is emptied
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_ROWS_IN_USE)
				rows = clamp_reg(val & 8'h3F, MAX_ROWS);
			else if (idx == REG_COLS_IN_USE)
				cols = clamp_reg(val, MAX_COLS);
			else
				return;
			empty_ring();
		endfunction

		// work out the result of one accepted transaction and queue it
		function void take_item(stlb_item_t it);
			stlb_res_t   r;
			int unsigned slot;
			r = '0;
			case (it.action)
				ACT_WRITE: begin
					r.data_char = it.char_code;
					if (it.starts_message) begin
						message_ended = 1'b0;
						open_line();
					end
					if (!message_ended) begin
						if (it.char_code == CHAR_NUL)
							message_ended = 1'b1;
						else if (it.char_code == CHAR_CR)
							column_pos = 0;
						else if (it.char_code == CHAR_LF)
							open_line();
						else begin
							if (column_pos >= cols)
								open_line();
							text[current_line*MAX_COLS + column_pos] = it.char_code;
							r.column_used = COL_W'(column_pos);
							column_pos++;
							r.wrote = 1'b1;
						end
					end
					r.row_physical = ROW_W'(current_line);
				end
				ACT_CLEAR: empty_ring();
				ACT_READ: begin
					r.column_used = it.read_col;
					r.data_char = CHAR_SPACE;
					if (it.read_row < line_count) begin
						r.row_valid = 1'b1;
						slot = (first_line + it.read_row) % rows;
						r.row_physical = ROW_W'(slot);
						if (it.read_col < cols)
							r.data_char = text[slot*MAX_COLS + it.read_col];
					end
				end
				default: ;
			endcase
			r.oldest_line = ROW_W'(first_line);
			r.lines_held = LINES_W'(line_count);
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("mismatch: %s", msg);
		endtask

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want)
				report($sformatf("result %0d %s: got %0d, want %0d", results_seen, name, got,
					want));
		endtask

		// compare one accepted result with the oldest one owed
		task check_result(stlb_res_t got);
			stlb_res_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", results_seen));
				return;
			end
			want = pending_results.pop_front();
			check_field("data_char", got.data_char, want.data_char);
			check_field("row_physical", got.row_physical, want.row_physical);
			check_field("column_used", got.column_used, want.column_used);
			check_field("wrote", got.wrote, want.wrote);
			check_field("row_valid", got.row_valid, want.row_valid);
			check_field("oldest_line", got.oldest_line, want.oldest_line);
			check_field("lines_held", got.lines_held, want.lines_held);
		endtask
	endclass

	logic clk;
	logic arst_n;

	stlb_item_if   cmd_if ();
	stlb_result_if rsp_if ();
	stlb_cfg_if    cfg_if ();

	scrolling_text_line_buffer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	line_scoreboard sb;
	stlb_item_t     seen_item;
	stlb_res_t      seen_res;
	int             send_idle_pct  = 0;
	int             recv_stall_pct = 0;
	int             items_sent     = 0;
	int             cycles         = 0;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// observe every transaction on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				seen_item.action = cmd_if.action;
				seen_item.char_code = cmd_if.char_code;
				seen_item.starts_message = cmd_if.starts_message;
				seen_item.read_row = cmd_if.read_row;
				seen_item.read_col = cmd_if.read_col;
				sb.take_item(seen_item);
			end
			if (cfg_if.valid && cfg_if.ready)
				sb.write_reg(cfg_if.index, cfg_if.data);
			if (rsp_if.valid && rsp_if.ready) begin
				seen_res.data_char = rsp_if.data_char;
				seen_res.row_physical = rsp_if.row_physical;
				seen_res.column_used = rsp_if.column_used;
				seen_res.wrote = rsp_if.wrote;
				seen_res.row_valid = rsp_if.row_valid;
				seen_res.oldest_line = rsp_if.oldest_line;
				seen_res.lines_held = rsp_if.lines_held;
				sb.check_result(seen_res);
			end
		end
	end

	// result receiver with random back-pressure
	always @(negedge clk)
		rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic stlb_item_t make_item(logic [1:0] act, logic [CHAR_W-1:0] ch, logic st,
			logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		stlb_item_t it;
		it.action = act;
		it.char_code = ch;
		it.starts_message = st;
		it.read_row = row;
		it.read_col = col;
		return it;
	endfunction

	// drive one transaction, with random idle cycles ahead of it
	task automatic send_item(input stlb_item_t it);
		bit dropped;
		dropped = it.action == ACT_NONE ||
			(it.action == ACT_WRITE && !it.starts_message && sb.message_ended);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.action <= it.action;
		cmd_if.char_code <= it.char_code;
		cmd_if.starts_message <= it.starts_message;
		cmd_if.read_row <= it.read_row;
		cmd_if.read_col <= it.read_col;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		@(negedge clk);
		if (!dropped)
			items_sent++;
	endtask

	task automatic put_char(logic [CHAR_W-1:0] ch, logic st);
		send_item(make_item(ACT_WRITE, ch, st, ROW_W'($urandom), COL_W'($urandom)));
	endtask

	task automatic put_read(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
		send_item(make_item(ACT_READ, CHAR_W'($urandom), 1'($urandom), row, col));
	endtask

	// any byte except the two line controls and nul
	function automatic logic [CHAR_W-1:0] text_char();
		logic [CHAR_W-1:0] ch;
		ch = CHAR_CR;
		while (ch == CHAR_CR || ch == CHAR_LF)
			ch = CHAR_W'($urandom_range(1, 255));
		return ch;
	endfunction

	// mostly reads of held lines inside the line width
	task automatic read_somewhere();
		if (sb.line_count != 0 && $urandom_range(99) < 75)
			put_read(ROW_W'($urandom_range(sb.line_count - 1)),
				COL_W'($urandom_range(sb.cols - 1)));
		else
			put_read(ROW_W'($urandom), COL_W'($urandom));
	endtask

	// one message: opening character, body with line controls, usually a nul
	task automatic send_message(int len, bit plain);
		logic [CHAR_W-1:0] first_ch;
		int                pick;
		pick = $urandom_range(99);
		if (pick < 6)
			first_ch = CHAR_CR;
		else if (pick < 12)
			first_ch = CHAR_LF;
		else if (pick < 15)
			first_ch = CHAR_NUL;
		else
			first_ch = text_char();
		put_char(first_ch, 1'b1);
		for (int i = 1; i < len; i++) begin
			if ($urandom_range(99) < 15)
				read_somewhere();
			pick = $urandom_range(99);
			if (plain || pick >= 17)
				put_char(text_char(), 1'b0);
			else if (pick < 6)
				put_char(CHAR_CR, 1'b0);
			else if (pick < 14)
				put_char(CHAR_LF, 1'b0);
			else
				put_char(text_char(), 1'b1);
		end
		if ($urandom_range(99) < 85)
			put_char(CHAR_NUL, 1'b0);
	endtask

	// reads, clears, unused actions and stray characters between messages
	task automatic send_noise();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			read_somewhere();
		else if (pick < 64)
			send_item(make_item(ACT_CLEAR, CHAR_W'($urandom), 1'($urandom),
				ROW_W'($urandom), COL_W'($urandom)));
		else if (pick < 70)
			send_item(make_item(ACT_NONE, CHAR_W'($urandom), 1'($urandom),
				ROW_W'($urandom), COL_W'($urandom)));
		else
			put_char(CHAR_W'($urandom), 1'b0);
	endtask

	// let every owed result arrive, then give the block time to settle
	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one register write; the caller drops valid after the last one
	task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 21; recv_stall_pct = 21; end
		endcase
	endtask

	// one random phase under a given ring shape and idling pattern
	task automatic run_phase(logic [CFG_DATA_W-1:0] rows_val, logic [CFG_DATA_W-1:0] cols_val,
			int mode);
		wait_idle();
		program_reg(REG_ROWS_IN_USE, rows_val);
		program_reg(REG_COLS_IN_USE, cols_val);
		cfg_if.valid <= 1'b0;
		set_idling(mode);
		items_sent = 0;
		while (items_sent < BUDGET) begin
			if ($urandom_range(99) < 65) begin
				if ($urandom_range(99) < 10)
					send_message($urandom_range(sb.cols, sb.cols + 10), 1'b1);
				else
					send_message($urandom_range(1, 20), 1'b0);
			end else begin
				repeat ($urandom_range(1, 4)) send_noise();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.action = ACT_WRITE;
		cmd_if.char_code = CHAR_NUL;
		cmd_if.starts_message = 1'b0;
		cmd_if.read_row = '0;
		cmd_if.read_col = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_ROWS_IN_USE;
		cfg_if.data = '0;
		rsp_if.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset shape: empty ring, then one full-width line
		put_read(0, 0);
		put_char(8'h41, 1'b1);
		put_read(0, COL_W'(MAX_COLS - 1));
		put_char(CHAR_NUL, 1'b0);

		// directed: two lines of three columns
		wait_idle();
		program_reg(REG_ROWS_IN_USE, 8'd2);
		program_reg(REG_COLS_IN_USE, 8'd3);
		cfg_if.valid <= 1'b0;
		put_char(8'h41, 1'b0);
		put_char(8'h48, 1'b1);
		put_char(8'h69, 1'b0);
		put_char(8'hFF, 1'b0);
		put_char(8'h78, 1'b0);
		put_char(CHAR_CR, 1'b0);
		put_char(8'h79, 1'b0);
		put_char(CHAR_LF, 1'b0);
		put_char(8'h01, 1'b0);
		put_char(CHAR_NUL, 1'b0);
		put_char(8'h7A, 1'b0);
		put_read(0, 0);
		put_read(1, 2);
		put_read(1, COL_W'(MAX_COLS - 1));
		put_read(ROW_W'(MAX_ROWS - 1), COL_W'(MAX_COLS - 1));
		put_char(CHAR_NUL, 1'b1);
		put_char(CHAR_LF, 1'b1);
		put_char(CHAR_CR, 1'b1);
		send_item(make_item(ACT_NONE, 8'h55, 1'b1, 5'd3, 7'd3));
		send_item(make_item(ACT_CLEAR, 8'hAA, 1'b0, 5'd0, 7'd0));
		put_read(0, 0);
		put_char(8'h71, 1'b0);

		// random phases over several ring shapes, out of range values among them
		run_phase(8'd32, 8'd128, 0);
		run_phase(8'd1, 8'd1, 1);
		run_phase(8'd5, 8'd8, 2);
		run_phase(8'd0, 8'd0, 3);
		run_phase(8'd32, 8'd4, 0);
		run_phase(8'd3, 8'd128, 1);
		run_phase(8'hFF, 8'hFF, 2);
		run_phase(8'd7, 8'd13, 3);
		run_phase(8'd2, 8'd2, 1);

		wait_idle();
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
